FILE: rtl/core/rss_pkg.sv
// shared types, register codes and reset values for the range scan segmenter
`timescale 1ns / 1ps
`default_nettype none

package rss_pkg;

  localparam int unsigned MAX_POINTS_DEF = 1024;

  localparam int unsigned RANGE_W   = 16;
  localparam int unsigned POS_W     = 21;
  localparam int unsigned LIMIT_W   = 20;
  localparam int unsigned MINPTS_W  = 11;
  localparam int unsigned OBJ_W     = 8;
  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned CFG_DW    = 20;

  localparam logic [CFG_AW-1:0] REG_RANGE_FLOOR    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MIN_POINTS     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MAX_OBJECTS    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_JUMP_THRESHOLD = 3'd3;
  localparam logic [CFG_AW-1:0] REG_X_LIMIT        = 3'd4;
  localparam logic [CFG_AW-1:0] REG_Y_LIMIT        = 3'd5;

  localparam logic [RANGE_W-1:0]  RST_RANGE_FLOOR    = 16'd0;
  localparam logic [MINPTS_W-1:0] RST_MIN_POINTS     = 11'd3;
  localparam logic [OBJ_W-1:0]    RST_MAX_OBJECTS    = 8'd16;
  localparam logic [RANGE_W-1:0]  RST_JUMP_THRESHOLD = 16'd90;
  localparam logic [LIMIT_W-1:0]  RST_X_LIMIT        = 20'd1300;
  localparam logic [LIMIT_W-1:0]  RST_Y_LIMIT        = 20'd800;

  typedef struct packed {
    logic [RANGE_W-1:0]  range_floor;
    logic [MINPTS_W-1:0] min_points;
    logic [OBJ_W-1:0]    max_objects;
    logic [RANGE_W-1:0]  jump_threshold;
    logic [LIMIT_W-1:0]  x_limit;
    logic [LIMIT_W-1:0]  y_limit;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/rss_cfg.sv
// configuration register file of the range scan segmenter
`timescale 1ns / 1ps
`default_nettype none

module rss_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [rss_pkg::CFG_AW-1:0] cfg_index_i,
  input  wire logic [rss_pkg::CFG_DW-1:0] cfg_data_i,
  output rss_pkg::cfg_t                   cfg_o
);

  rss_pkg::cfg_t cfg_q;
  rss_pkg::cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        rss_pkg::REG_RANGE_FLOOR:    cfg_d.range_floor    = cfg_data_i[rss_pkg::RANGE_W-1:0];
        rss_pkg::REG_MIN_POINTS:     cfg_d.min_points     = cfg_data_i[rss_pkg::MINPTS_W-1:0];
        rss_pkg::REG_MAX_OBJECTS:    cfg_d.max_objects    = cfg_data_i[rss_pkg::OBJ_W-1:0];
        rss_pkg::REG_JUMP_THRESHOLD: cfg_d.jump_threshold = cfg_data_i[rss_pkg::RANGE_W-1:0];
        rss_pkg::REG_X_LIMIT:        cfg_d.x_limit        = cfg_data_i[rss_pkg::LIMIT_W-1:0];
        rss_pkg::REG_Y_LIMIT:        cfg_d.y_limit        = cfg_data_i[rss_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_floor    <= rss_pkg::RST_RANGE_FLOOR;
      cfg_q.min_points     <= rss_pkg::RST_MIN_POINTS;
      cfg_q.max_objects    <= rss_pkg::RST_MAX_OBJECTS;
      cfg_q.jump_threshold <= rss_pkg::RST_JUMP_THRESHOLD;
      cfg_q.x_limit        <= rss_pkg::RST_X_LIMIT;
      cfg_q.y_limit        <= rss_pkg::RST_Y_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/range_scan_segmenter_top.sv
// top level of the range scan segmenter: input register, run tracking, result register
`timescale 1ns / 1ps
`default_nettype none

// Splits a range scan, one point per request, into runs of valid points and reports
// each run of at least min_points points (start index and length) until max_objects
// are reported; the last point of a scan, or the point at index MAX_POINTS-1, always
// gives a result marked scan_end. A point enters an input register and is evaluated
// by one compare-and-subtract stage that writes the result register, so one point is
// taken every clock and its result is driven on the outputs by the result register;
// the input stalls only while a held result blocks the result register.
// Configuration writes are taken every cycle and must be made while no point is in
// flight.

module range_scan_segmenter_top #(
  parameter int unsigned MAX_POINTS = rss_pkg::MAX_POINTS_DEF,
  localparam int unsigned IDX_W = $clog2(MAX_POINTS),
  localparam int unsigned CNT_W = IDX_W + 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,

  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [rss_pkg::CFG_AW-1:0]  cfg_index_i,
  input  wire logic [rss_pkg::CFG_DW-1:0]  cfg_data_i,

  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [rss_pkg::RANGE_W-1:0] range_i,
  input  wire logic [rss_pkg::POS_W-1:0]   pos_x_i,
  input  wire logic [rss_pkg::POS_W-1:0]   pos_y_i,
  input  wire logic                        last_point_i,

  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             has_object_o,
  output logic [IDX_W-1:0]                 start_index_o,
  output logic [CNT_W-1:0]                 point_count_o,
  output logic [rss_pkg::OBJ_W-1:0]        objects_so_far_o,
  output logic                             scan_end_o
);

  localparam int unsigned CMP_W = (CNT_W > rss_pkg::MINPTS_W) ? CNT_W : rss_pkg::MINPTS_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_POINTS - 1);

  rss_pkg::cfg_t cfg;

  rss_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input register
  logic                        pt_valid_q;
  logic [rss_pkg::RANGE_W-1:0] pt_range_q;
  logic [rss_pkg::POS_W-1:0]   pt_x_q;
  logic [rss_pkg::POS_W-1:0]   pt_y_q;
  logic                        pt_last_q;

  // run state
  logic [IDX_W-1:0]            idx_q, idx_d;
  logic                        in_run_q, in_run_d;
  logic [IDX_W-1:0]            run_start_q, run_start_d;
  logic [rss_pkg::RANGE_W-1:0] prev_range_q, prev_range_d;
  logic [rss_pkg::OBJ_W-1:0]   obj_total_q, obj_total_d;
  logic                        list_full_q, list_full_d;

  // result register
  logic                        res_valid_q, res_valid_d;
  logic                        res_has_q;
  logic [IDX_W-1:0]            res_start_q;
  logic [CNT_W-1:0]            res_count_q;
  logic [rss_pkg::OBJ_W-1:0]   res_objs_q;
  logic                        res_end_q;

  logic                        res_free;
  logic                        pt_take;
  logic                        in_take;
  logic                        last;
  logic [rss_pkg::POS_W-1:0]   abs_x;
  logic [rss_pkg::POS_W-1:0]   abs_y;
  logic [rss_pkg::RANGE_W-1:0] step_abs;
  logic                        pt_ok;
  logic                        closing;
  logic [IDX_W-1:0]            run_len;
  logic                        reported;
  logic [IDX_W-1:0]            rep_start;
  logic [CNT_W-1:0]            rep_count;

  assign res_free   = !res_valid_q || !out_stall_i;
  assign pt_take    = pt_valid_q && res_free;
  assign in_stall_o = pt_valid_q && !res_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    abs_x    = pt_x_q[rss_pkg::POS_W-1] ? (~pt_x_q + 1'b1) : pt_x_q;
    abs_y    = pt_y_q[rss_pkg::POS_W-1] ? (~pt_y_q + 1'b1) : pt_y_q;
    step_abs = (pt_range_q >= prev_range_q) ? (pt_range_q - prev_range_q)
                                            : (prev_range_q - pt_range_q);
    last     = pt_last_q || (idx_q == LAST_IDX);
    pt_ok    = (pt_range_q >= cfg.range_floor)
            && (abs_x <= {1'b0, cfg.x_limit})
            && (abs_y <= {1'b0, cfg.y_limit});
    closing  = in_run_q && (last || !pt_ok || (step_abs >= cfg.jump_threshold));
    run_len  = idx_q - run_start_q;

    reported    = 1'b0;
    rep_start   = '0;
    rep_count   = '0;
    in_run_d    = in_run_q;
    run_start_d = run_start_q;
    obj_total_d = obj_total_q;
    list_full_d = list_full_q;

    if (closing) begin
      in_run_d = 1'b0;
      if ((CMP_W'(run_len) >= CMP_W'(cfg.min_points)) && !list_full_q) begin
        if (obj_total_q < cfg.max_objects) begin
          obj_total_d = obj_total_q + 1'b1;
          reported    = 1'b1;
          rep_start   = run_start_q;
          rep_count   = CNT_W'(run_len);
        end else begin
          list_full_d = 1'b1;
        end
      end
    end

    if (!last && pt_ok && !in_run_d) begin
      in_run_d    = 1'b1;
      run_start_d = idx_q;
    end

    prev_range_d = pt_ok ? pt_range_q : prev_range_q;
    idx_d        = idx_q + 1'b1;
    if (last) begin
      idx_d       = '0;
      in_run_d    = 1'b0;
      list_full_d = 1'b0;
    end

    res_valid_d = res_free ? (pt_take && (reported || last)) : res_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_valid_q   <= 1'b0;
      idx_q        <= '0;
      in_run_q     <= 1'b0;
      run_start_q  <= '0;
      prev_range_q <= '0;
      obj_total_q  <= '0;
      list_full_q  <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (in_take) begin
        pt_valid_q <= 1'b1;
      end else if (pt_take) begin
        pt_valid_q <= 1'b0;
      end
      if (pt_take) begin
        idx_q        <= idx_d;
        in_run_q     <= in_run_d;
        run_start_q  <= run_start_d;
        prev_range_q <= prev_range_d;
        obj_total_q  <= last ? '0 : obj_total_d;
        list_full_q  <= list_full_d;
      end
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pt_range_q <= range_i;
      pt_x_q     <= pos_x_i;
      pt_y_q     <= pos_y_i;
      pt_last_q  <= last_point_i;
    end
    if (pt_take && res_free) begin
      res_has_q   <= reported;
      res_start_q <= rep_start;
      res_count_q <= rep_count;
      res_objs_q  <= obj_total_d;
      res_end_q   <= last;
    end
  end

  assign out_valid_o      = res_valid_q;
  assign has_object_o     = res_has_q;
  assign start_index_o    = res_start_q;
  assign point_count_o    = res_count_q;
  assign objects_so_far_o = res_objs_q;
  assign scan_end_o       = res_end_q;

endmodule

`default_nettype wire

FILE: tb/range_scan_segmenter_top_tb.sv
// self-checking testbench for range_scan_segmenter_top: directed and random scans
`timescale 1ns / 1ps

module range_scan_segmenter_top_tb;
  import rss_pkg::*;

  localparam int SCAN_POINTS = MAX_POINTS_DEF;
  localparam int IDX_W = $clog2(SCAN_POINTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int FLUSH_CYCLES = 8;
  localparam int COORD_MAX = (1 << LIMIT_W) - 1;
  localparam int RANGE_MAX = (1 << RANGE_W) - 1;
  localparam logic [CFG_AW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_AW-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic             has_object;
    logic [IDX_W-1:0] start_index;
    logic [CNT_W-1:0] point_count;
    logic [OBJ_W-1:0] objects_so_far;
    logic             scan_end;
  } seg_result_t;

  class segment_tracker;
    cfg_t               cfg;
    logic [IDX_W-1:0]   point_index;
    logic               in_run;
    logic [IDX_W-1:0]   run_start;
    logic [RANGE_W-1:0] prev_range;
    logic [OBJ_W-1:0]   object_total;
    logic               list_full;
    seg_result_t        pending_objects[$];
    int                 mismatches;

    function new();
      cfg.range_floor    = RST_RANGE_FLOOR;
      cfg.min_points     = RST_MIN_POINTS;
      cfg.max_objects    = RST_MAX_OBJECTS;
      cfg.jump_threshold = RST_JUMP_THRESHOLD;
      cfg.x_limit        = RST_X_LIMIT;
      cfg.y_limit        = RST_Y_LIMIT;
      point_index  = '0;
      in_run       = 1'b0;
      run_start    = '0;
      prev_range   = '0;
      object_total = '0;
      list_full    = 1'b0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        REG_RANGE_FLOOR:    cfg.range_floor    = data[RANGE_W-1:0];
        REG_MIN_POINTS:     cfg.min_points     = data[MINPTS_W-1:0];
        REG_MAX_OBJECTS:    cfg.max_objects    = data[OBJ_W-1:0];
        REG_JUMP_THRESHOLD: cfg.jump_threshold = data[RANGE_W-1:0];
        REG_X_LIMIT:        cfg.x_limit        = data[LIMIT_W-1:0];
        REG_Y_LIMIT:        cfg.y_limit        = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_point(logic [RANGE_W-1:0] rng, logic [POS_W-1:0] px,
                             logic [POS_W-1:0] py, logic fin);
      int          ax;
      int          ay;
      int          step;
      int          len;
      logic        last;
      logic        ok;
      logic        close;
      logic        reported;
      seg_result_t res;
      ax = int'($signed(px));
      ay = int'($signed(py));
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      last = fin || (point_index == IDX_W'(SCAN_POINTS - 1));
      ok = (rng >= cfg.range_floor) && (ax <= int'(cfg.x_limit))
           && (ay <= int'(cfg.y_limit));
      res = '0;
      reported = 1'b0;
      if (in_run) begin
        close = last || !ok;
        if (!close) begin
          step = int'(rng) - int'(prev_range);
          if (step < 0) step = -step;
          if (step >= int'(cfg.jump_threshold)) close = 1'b1;
        end
        if (close) begin
          len = int'(point_index) - int'(run_start);
          in_run = 1'b0;
          if (len >= int'(cfg.min_points) && !list_full) begin
            if (object_total < cfg.max_objects) begin
              object_total = object_total + 1'b1;
              reported = 1'b1;
              res.start_index = run_start;
              res.point_count = CNT_W'(len);
            end else begin
              list_full = 1'b1;
            end
          end
        end
      end
      if (!last && ok && !in_run) begin
        in_run = 1'b1;
        run_start = point_index;
      end
      if (ok) prev_range = rng;
      if (reported || last) begin
        res.has_object = reported;
        res.objects_so_far = object_total;
        res.scan_end = last;
        pending_objects.push_back(res);
      end
      if (last) begin
        point_index = '0;
        in_run = 1'b0;
        object_total = '0;
        list_full = 1'b0;
      end else begin
        point_index = point_index + 1'b1;
      end
    endfunction

    function void note_mismatch(string what, seg_result_t want, seg_result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: want %b/%0d/%0d/%0d/%b got %b/%0d/%0d/%0d/%b",
                 what, want.has_object, want.start_index, want.point_count,
                 want.objects_so_far, want.scan_end, got.has_object, got.start_index,
                 got.point_count, got.objects_so_far, got.scan_end);
    endfunction

    function void check_result(seg_result_t got);
      seg_result_t want;
      if (pending_objects.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
        return;
      end
      want = pending_objects.pop_front();
      if (got.has_object !== want.has_object || got.start_index !== want.start_index
          || got.point_count !== want.point_count
          || got.objects_so_far !== want.objects_so_far || got.scan_end !== want.scan_end)
        note_mismatch("result mismatch", want, got);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CFG_AW-1:0]   cfg_index_i;
  logic [CFG_DW-1:0]   cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [RANGE_W-1:0]  range_i;
  logic [POS_W-1:0]    pos_x_i;
  logic [POS_W-1:0]    pos_y_i;
  logic                last_point_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                has_object_o;
  logic [IDX_W-1:0]    start_index_o;
  logic [CNT_W-1:0]    point_count_o;
  logic [OBJ_W-1:0]    objects_so_far_o;
  logic                scan_end_o;

  segment_tracker tracker;
  seg_result_t    observed;
  int unsigned    cycle_count = 0;
  bit             quiet;
  bit             hold_off_req;
  int             gap_pct;
  int             walk_range;

  range_scan_segmenter_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .range_i          (range_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .last_point_i     (last_point_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .has_object_o     (has_object_o),
    .start_index_o    (start_index_o),
    .point_count_o    (point_count_o),
    .objects_so_far_o (objects_so_far_o),
    .scan_end_o       (scan_end_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      observed.has_object     = has_object_o;
      observed.start_index    = start_index_o;
      observed.point_count    = point_count_o;
      observed.objects_so_far = objects_so_far_o;
      observed.scan_end       = scan_end_o;
      tracker.check_result(observed);
    end
  end

  // result side back-pressure: random bursts, one long hold on request
  initial begin
    int span;
    bit hold;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold = 1'b1;
        span = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end else if (quiet) begin
        hold = 1'b0;
        span = 1;
      end else if ($urandom_range(0, 1) == 1) begin
        hold = 1'b1;
        span = $urandom_range(1, 12);
      end else begin
        hold = 1'b0;
        span = $urandom_range(1, 24);
      end
      @(negedge clk_i);
      out_stall_i <= hold;
      repeat (span - 1) @(negedge clk_i);
    end
  end

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clamp_range(int v, int md);
    return (v < md) ? md : ((v > RANGE_MAX) ? RANGE_MAX : v);
  endfunction

  function automatic int drift(int cur, int md, int jt);
    int bound;
    bound = (jt > 400) ? 400 : jt - 1;
    if (bound < 0) bound = 0;
    return clamp_range(cur + rand_between(-bound, bound), md);
  endfunction

  function automatic int jump_from(int cur, int md, int jt);
    int hop;
    hop = jt + $urandom_range(0, 100);
    if (cur + hop <= RANGE_MAX && (cur - hop < md || $urandom_range(0, 1) == 1))
      return cur + hop;
    if (cur - hop >= md) return cur - hop;
    return rand_between(md, RANGE_MAX);
  endfunction

  function automatic int inside_coord(int lim);
    case ($urandom_range(0, 9))
      0: return lim;
      1: return -lim;
      default: return rand_between(-lim, lim);
    endcase
  endfunction

  function automatic int outside_coord(int lim);
    int mag;
    if (lim >= COORD_MAX || $urandom_range(0, 5) == 0) return -(COORD_MAX + 1);
    mag = ($urandom_range(0, 2) == 0) ? lim + 1 : rand_between(lim + 1, COORD_MAX);
    return ($urandom_range(0, 1) == 1) ? mag : -mag;
  endfunction

  task automatic idle_input(int cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic send_point(int rng, int px, int py, bit fin);
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    range_i      <= rng[RANGE_W-1:0];
    pos_x_i      <= px[POS_W-1:0];
    pos_y_i      <= py[POS_W-1:0];
    last_point_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_point(range_i, pos_x_i, pos_y_i, last_point_i);
    if (!quiet && $urandom_range(0, 99) < gap_pct) idle_input($urandom_range(1, 12));
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(int md, int mp, int mo, int jt, int xl, int yl);
    write_reg(REG_RANGE_FLOOR, md[CFG_DW-1:0]);
    write_reg(REG_MIN_POINTS, mp[CFG_DW-1:0]);
    write_reg(REG_MAX_OBJECTS, mo[CFG_DW-1:0]);
    write_reg(REG_JUMP_THRESHOLD, jt[CFG_DW-1:0]);
    write_reg(REG_X_LIMIT, xl[CFG_DW-1:0]);
    write_reg(REG_Y_LIMIT, yl[CFG_DW-1:0]);
  endtask

  task automatic random_config();
    int md;
    int mp;
    int mo;
    int jt;
    int xl;
    int yl;
    md = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 400);
    mp = $urandom_range(0, 5);
    mo = ($urandom_range(0, 7) == 0) ? int'($urandom) : $urandom_range(1, 12);
    jt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(20, 300);
    xl = ($urandom_range(0, 4) == 0) ? int'($urandom) : $urandom_range(200, 3000);
    yl = ($urandom_range(0, 4) == 0) ? int'($urandom) : $urandom_range(200, 3000);
    set_config(md, mp, mo, jt, xl, yl);
  endtask

  // drain all pending results before touching the registers
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending_objects.size() != 0) @(posedge clk_i);
    repeat (FLUSH_CYCLES) @(posedge clk_i);
  endtask

  task automatic stream_scan(int len, bit close_scan);
    int md;
    int jt;
    int xl;
    int yl;
    int pick;
    int rng;
    int px;
    int py;
    bit fin;
    md = int'(tracker.cfg.range_floor);
    jt = int'(tracker.cfg.jump_threshold);
    xl = int'(tracker.cfg.x_limit);
    yl = int'(tracker.cfg.y_limit);
    walk_range = rand_between(md, (md + 3000 > RANGE_MAX) ? RANGE_MAX : md + 3000);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      px = inside_coord(xl);
      py = inside_coord(yl);
      fin = close_scan && (i == len - 1);
      if (pick < 4) begin
        rng = int'($urandom);
        px = int'($urandom);
        py = int'($urandom);
        fin = fin || ($urandom_range(0, 3) == 0);
      end else begin
        if (pick < 12) walk_range = jump_from(walk_range, md, jt);
        else walk_range = drift(walk_range, md, jt);
        rng = walk_range;
        if (pick >= 12 && pick < 20) begin
          case ($urandom_range(0, 2))
            0: begin
              if (md > 0) rng = $urandom_range(0, md - 1);
              else px = outside_coord(xl);
            end
            1: px = outside_coord(xl);
            default: py = outside_coord(yl);
          endcase
        end
      end
      send_point(rng, px, py, fin);
    end
  endtask

  task automatic run_phase(int budget);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      stream_scan(len, $urandom_range(0, 9) != 0);
      sent += len;
    end
  endtask

  initial begin
    tracker = new();
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    range_i      = '0;
    pos_x_i      = '0;
    pos_y_i      = '0;
    last_point_i = 1'b0;
    out_stall_i  = 1'b0;
    quiet        = 1'b0;
    hold_off_req = 1'b0;
    gap_pct      = 20;
    walk_range   = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: exact jump step, limits on and just past the edge
    send_point(0, 0, 0, 1'b0);
    send_point(50, 10, -10, 1'b0);
    send_point(139, 100, 100, 1'b0);
    send_point(229, 0, 0, 1'b0);
    send_point(229, 1300, 800, 1'b0);
    send_point(229, -1300, -800, 1'b0);
    send_point(229, 1301, 0, 1'b0);
    send_point(229, -(COORD_MAX + 1), 0, 1'b0);
    send_point(229, 0, -801, 1'b0);
    send_point(RANGE_MAX, 0, COORD_MAX, 1'b0);
    send_point(RANGE_MAX, -5, 5, 1'b0);
    send_point(RANGE_MAX, 1, 1, 1'b0);
    send_point(RANGE_MAX, 2, 2, 1'b1);
    send_point(10, 0, 0, 1'b1);
    send_point(100, 0, 0, 1'b0);
    send_point(100, 0, 0, 1'b0);
    send_point(100, 0, 0, 1'b0);
    send_point(100, 5000, 0, 1'b1);

    // zero threshold, zero min_points, list of one
    settle();
    write_reg(REG_SPARE_LO, CFG_DW'($urandom));
    write_reg(REG_SPARE_HI, CFG_DW'($urandom));
    set_config(0, 0, 1, 0, 1300, 800);
    for (int i = 0; i < 5; i++) send_point(100 + i, i, -i, 1'b0);
    send_point(100, 0, 0, 1'b1);

    // empty object list
    settle();
    set_config(0, 1, 0, 90, 1300, 800);
    send_point(300, 0, 0, 1'b0);
    send_point(300, 0, 0, 1'b0);
    send_point(300, 0, 9000, 1'b0);
    send_point(300, 0, 0, 1'b0);
    send_point(300, 0, 0, 1'b1);

    settle();
    set_config(0, 1024, 255, RANGE_MAX, COORD_MAX, COORD_MAX);
    run_phase(100);
    settle();
    set_config(RANGE_MAX, 0, 255, 0, 0, 0);
    run_phase(100);
    for (int p = 0; p < 5; p++) begin
      settle();
      random_config();
      run_phase(100);
    end

    // one scan that runs past the point limit without a last flag
    settle();
    set_config(50, 2, 40, 120, 2000, 1500);
    gap_pct = 10;
    stream_scan(1030, 1'b0);
    stream_scan(10, 1'b1);

    // receiver holds off while points keep coming
    settle();
    set_config(0, 0, 255, 0, 1300, 800);
    gap_pct = 0;
    hold_off_req = 1'b1;
    stream_scan(60, 1'b1);

    settle();
    quiet = 1'b1;
    random_config();
    run_phase(100);

    settle();
    if (tracker.mismatches == 0 && tracker.pending_objects.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/rss_pkg.sv
rtl/core/rss_cfg.sv
rtl/core/range_scan_segmenter_top.sv
tb/range_scan_segmenter_top_tb.sv
